// ===== sv/aled_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aled_pkg
// Shared types and constants of the addressable LED serial encoder.
// ----------------------------------------------------------------------------
package aled_pkg;

  // Input function codes.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_BYTE  = 2'd1;
  localparam logic [1:0] FUNC_PIXEL = 2'd2;
  localparam logic [1:0] FUNC_LATCH = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_ZERO_HIGH = 3'd0;
  localparam logic [2:0] REG_ZERO_LOW  = 3'd1;
  localparam logic [2:0] REG_ONE_HIGH  = 3'd2;
  localparam logic [2:0] REG_ONE_LOW   = 3'd3;
  localparam logic [2:0] REG_LATCH     = 3'd4;

  localparam logic [9:0]  DEF_ZERO_HIGH = 10'd35;
  localparam logic [9:0]  DEF_ZERO_LOW  = 10'd80;
  localparam logic [9:0]  DEF_ONE_HIGH  = 10'd70;
  localparam logic [9:0]  DEF_ONE_LOW   = 10'd60;
  localparam logic [15:0] DEF_LATCH     = 16'd5500;

  localparam int unsigned PADDR_W = 5;

  // Command queue between front and back.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_LOAD,
    CMD_LATCH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [23:0] bits;
    logic [4:0]  nbits;
  } cmd_t;

  typedef struct packed {
    logic [9:0]  zero_high;
    logic [9:0]  zero_low;
    logic [9:0]  one_high;
    logic [9:0]  one_low;
    logic [15:0] latch;
  } timing_t;

endpackage
`default_nettype wire

// ===== sv/addressable_led_serial_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// addressable_led_serial_encoder
// One-wire addressable LED pulse encoder with APB timing registers.
// ----------------------------------------------------------------------------
// Each input transaction is one tick of the pulse timer, or a byte load, pixel
// load or latch command, and produces exactly one result transaction carrying
// the line state after it. The block sustains one transaction per clock cycle
// while the output is not stalled; a result passes through the front decode
// register, then the four-entry command queue, then the engine output register,
// which is written as the command leaves the queue, and the queue lets the input
// keep flowing while the output is stalled, until the queue is full.
// Pixels are sent green, red, blue, MSB first. Timing registers are 10 bits
// (bit high and low times) and 16 bits (latch time), at byte addresses 0 to 16;
// writing zero restores a register's default.
module addressable_led_serial_encoder import aled_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_func,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic [7:0]         in_red,
  input  wire logic [7:0]         in_green,
  input  wire logic [7:0]         in_blue,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_pin_level,
  output logic                    out_pin_drive,
  output logic                    out_accepted,
  output logic                    out_busy_res,
  output logic                    out_frame_done,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  timing_t timing;
  logic    push;
  cmd_t    push_cmd;
  logic    q_full;
  logic    pop;
  logic    q_not_empty;
  cmd_t    q_head;

  aled_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .timing  (timing)
  );

  aled_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_data_byte (in_data_byte),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .push         (push),
    .push_cmd     (push_cmd),
    .q_full       (q_full)
  );

  aled_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  aled_engine #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .timing         (timing),
    .q_not_empty    (q_not_empty),
    .q_head         (q_head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pin_level  (out_pin_level),
    .out_pin_drive  (out_pin_drive),
    .out_accepted   (out_accepted),
    .out_busy_res   (out_busy_res),
    .out_frame_done (out_frame_done)
  );

endmodule
`default_nettype wire

// ===== sv/aled_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aled_cfg
// APB register file holding the pulse timing. A zero write loads the default.
// ----------------------------------------------------------------------------
module aled_cfg import aled_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready,
  output timing_t                   timing
);

  timing_t     timing_r;
  timing_t     timing_nxt;
  logic [2:0]  idx;
  logic        wr;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign timing = timing_r;

  always_comb begin
    timing_nxt = timing_r;
    if (wr) begin
      unique case (idx)
        REG_ZERO_HIGH: timing_nxt.zero_high =
          (pwdata[9:0] == 10'd0) ? DEF_ZERO_HIGH : pwdata[9:0];
        REG_ZERO_LOW:  timing_nxt.zero_low =
          (pwdata[9:0] == 10'd0) ? DEF_ZERO_LOW : pwdata[9:0];
        REG_ONE_HIGH:  timing_nxt.one_high =
          (pwdata[9:0] == 10'd0) ? DEF_ONE_HIGH : pwdata[9:0];
        REG_ONE_LOW:   timing_nxt.one_low =
          (pwdata[9:0] == 10'd0) ? DEF_ONE_LOW : pwdata[9:0];
        REG_LATCH:     timing_nxt.latch =
          (pwdata[15:0] == 16'd0) ? DEF_LATCH : pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ZERO_HIGH: prdata = {22'd0, timing_r.zero_high};
      REG_ZERO_LOW:  prdata = {22'd0, timing_r.zero_low};
      REG_ONE_HIGH:  prdata = {22'd0, timing_r.one_high};
      REG_ONE_LOW:   prdata = {22'd0, timing_r.one_low};
      REG_LATCH:     prdata = {16'd0, timing_r.latch};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r <= '{zero_high: DEF_ZERO_HIGH, zero_low: DEF_ZERO_LOW,
                    one_high: DEF_ONE_HIGH, one_low: DEF_ONE_LOW,
                    latch: DEF_LATCH};
    end else begin
      timing_r <= timing_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/aled_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aled_front
// Accepts input items, decodes the function and assembles the bit pattern.
// ----------------------------------------------------------------------------
module aled_front import aled_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_func,
  input  wire logic [7:0] in_data_byte,
  input  wire logic [7:0] in_red,
  input  wire logic [7:0] in_green,
  input  wire logic [7:0] in_blue,
  output logic            push,
  output cmd_t            push_cmd,
  input  wire logic       q_full
);

  logic vld_r;
  logic vld_nxt;
  cmd_t cmd_r;
  cmd_t cmd_dec;
  logic take;

  assign in_stall = vld_r && q_full;
  assign take     = in_valid && !in_stall;
  assign push     = vld_r && !q_full;
  assign push_cmd = cmd_r;

  always_comb begin
    cmd_dec = '{kind: CMD_TICK, bits: 24'd0, nbits: 5'd0};
    unique case (in_func)
      FUNC_TICK:  cmd_dec.kind = CMD_TICK;
      FUNC_BYTE:  cmd_dec = '{kind: CMD_LOAD, bits: {in_data_byte, 16'd0}, nbits: 5'd8};
      FUNC_PIXEL: cmd_dec = '{kind: CMD_LOAD, bits: {in_green, in_red, in_blue},
                              nbits: 5'd24};
      FUNC_LATCH: cmd_dec.kind = CMD_LATCH;
      default: ;
    endcase
  end

  always_comb begin
    vld_nxt = vld_r;
    if (push) vld_nxt = 1'b0;
    if (take) vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= cmd_dec;
    end
  end

endmodule
`default_nettype wire

// ===== sv/aled_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aled_queue
// Short command queue between the front end and the pulse engine.
// ----------------------------------------------------------------------------
module aled_queue import aled_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output cmd_t      head
);

  cmd_t              slots_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r;
  logic [QPTR_W-1:0] rp_r;
  logic [QPTR_W:0]   cnt_r;
  logic [QPTR_W:0]   cnt_nxt;

  assign full      = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slots_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wp_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== sv/aled_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aled_engine
// Pulse engine: runs the bit and latch timing, one command per cycle while the
// output is not stalled, and holds the result in an output register.
// ----------------------------------------------------------------------------
module aled_engine import aled_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  timing_t   timing,
  input  wire logic q_not_empty,
  input  cmd_t      q_head,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic      out_pin_level,
  output logic      out_pin_drive,
  output logic      out_accepted,
  output logic      out_busy_res,
  output logic      out_frame_done
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HIGH,
    PH_LOW,
    PH_LATCH
  } phase_t;

  localparam logic [32:0] TMAX = (33'd1 << TIMER_WIDTH) - 33'd1;

  function automatic logic [TIMER_WIDTH-1:0] tload(input logic [15:0] v);
    logic [TIMER_WIDTH-1:0] r;
    if ({17'd0, v} > TMAX) r = '1;
    else                   r = TIMER_WIDTH'(v);
    return r;
  endfunction

  phase_t                 ph_r, ph_nxt;
  logic [TIMER_WIDTH-1:0] tick_r, tick_nxt, tick_dec;
  logic [23:0]            sh_r, sh_nxt;
  logic [4:0]             left_r, left_nxt;
  logic                   cur_r, cur_nxt;
  logic                   drv_r, drv_nxt;
  logic                   lvl_r, lvl_nxt;
  logic                   acc_nxt, done_nxt;
  logic                   ov_r, ov_nxt;
  logic                   o_lvl_r, o_drv_r, o_acc_r, o_busy_r, o_done_r;

  assign pop = q_not_empty && (!ov_r || !out_stall);

  assign out_valid      = ov_r;
  assign out_pin_level  = o_lvl_r;
  assign out_pin_drive  = o_drv_r;
  assign out_accepted   = o_acc_r;
  assign out_busy_res   = o_busy_r;
  assign out_frame_done = o_done_r;

  assign tick_dec = (tick_r != '0) ? tick_r - 1'b1 : tick_r;

  always_comb begin
    ph_nxt   = ph_r;
    tick_nxt = tick_r;
    sh_nxt   = sh_r;
    left_nxt = left_r;
    cur_nxt  = cur_r;
    drv_nxt  = drv_r;
    lvl_nxt  = lvl_r;
    acc_nxt  = 1'b0;
    done_nxt = 1'b0;
    if (q_head.kind == CMD_TICK) begin
      if (ph_r != PH_IDLE) begin
        tick_nxt = tick_dec;
        if (tick_dec == '0) begin
          unique case (ph_r)
            PH_HIGH: begin
              ph_nxt   = PH_LOW;
              tick_nxt = tload(cur_r ? {6'd0, timing.one_low} : {6'd0, timing.zero_low});
              lvl_nxt  = 1'b0;
            end
            PH_LOW: begin
              left_nxt = left_r - 5'd1;
              sh_nxt   = {sh_r[22:0], 1'b0};
              lvl_nxt  = 1'b0;
              if (left_nxt != 5'd0) begin
                // Next bit starts on the same tick the previous low time ends.
                cur_nxt  = sh_nxt[23];
                ph_nxt   = PH_HIGH;
                tick_nxt = tload(sh_nxt[23] ? {6'd0, timing.one_high}
                                            : {6'd0, timing.zero_high});
                lvl_nxt  = 1'b1;
                drv_nxt  = 1'b1;
              end else begin
                ph_nxt = PH_IDLE;
              end
            end
            PH_LATCH: begin
              ph_nxt   = PH_IDLE;
              drv_nxt  = 1'b0;
              lvl_nxt  = 1'b0;
              done_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
    end else if (ph_r == PH_IDLE) begin
      acc_nxt = 1'b1;
      if (q_head.kind == CMD_LOAD) begin
        sh_nxt   = q_head.bits;
        left_nxt = q_head.nbits;
        cur_nxt  = q_head.bits[23];
        ph_nxt   = PH_HIGH;
        tick_nxt = tload(q_head.bits[23] ? {6'd0, timing.one_high}
                                         : {6'd0, timing.zero_high});
        lvl_nxt  = 1'b1;
        drv_nxt  = 1'b1;
      end else begin
        ph_nxt   = PH_LATCH;
        tick_nxt = tload(timing.latch);
        lvl_nxt  = 1'b0;
        drv_nxt  = 1'b1;
      end
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (pop) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r     <= PH_IDLE;
      tick_r   <= '0;
      sh_r     <= '0;
      left_r   <= '0;
      cur_r    <= 1'b0;
      drv_r    <= 1'b0;
      lvl_r    <= 1'b0;
      ov_r     <= 1'b0;
      o_lvl_r  <= 1'b0;
      o_drv_r  <= 1'b0;
      o_acc_r  <= 1'b0;
      o_busy_r <= 1'b0;
      o_done_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (pop) begin
        ph_r     <= ph_nxt;
        tick_r   <= tick_nxt;
        sh_r     <= sh_nxt;
        left_r   <= left_nxt;
        cur_r    <= cur_nxt;
        drv_r    <= drv_nxt;
        lvl_r    <= lvl_nxt;
        o_lvl_r  <= lvl_nxt;
        o_drv_r  <= drv_nxt;
        o_acc_r  <= acc_nxt;
        o_busy_r <= (ph_nxt != PH_IDLE);
        o_done_r <= done_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/aled_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aled_checker
// Port-level checks of the LED encoder, bound to the top level.
// ----------------------------------------------------------------------------
module aled_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_pin_level,
  input wire logic out_pin_drive,
  input wire logic out_accepted,
  input wire logic out_busy_res,
  input wire logic out_frame_done
);

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid &&
      $stable({out_pin_level, out_pin_drive, out_accepted, out_busy_res,
               out_frame_done}))
    else $error("stalled result changed");

  // A released line never reads high.
  a_release_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pin_drive |-> !out_pin_level)
    else $error("released line shows high level");

  // End of a frame leaves the block idle with the line released.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> !out_busy_res && !out_pin_drive && !out_accepted)
    else $error("frame done while busy or driving");

  // Every taken command starts work and drives the line.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_busy_res && out_pin_drive)
    else $error("accepted command left block idle");

endmodule

bind addressable_led_serial_encoder aled_checker u_aled_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_pin_level  (out_pin_level),
  .out_pin_drive  (out_pin_drive),
  .out_accepted   (out_accepted),
  .out_busy_res   (out_busy_res),
  .out_frame_done (out_frame_done)
);
`default_nettype wire
